FILE: src/line_near_plane_clip_defines.svh
// assertion helpers
`ifndef LINE_NEAR_PLANE_CLIP_DEFINES_SVH
`define LINE_NEAR_PLANE_CLIP_DEFINES_SVH

`define LNPC_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("lnpc check failed");

`define LNPC_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("lnpc check failed");

`endif

FILE: src/lnpc_pkg.sv
package lnpc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_W = 32;
  // t needs FRAC_BITS+1 bits, range [0, 2^FRAC_BITS]
  localparam int T_W = FRAC_BITS + 1;
  localparam int DIST_W = WORD_W + 2;
  localparam int REM_W = DIST_W + 1;
  localparam int NUM_CELLS = T_W;
  localparam logic [WORD_W-2:0] NEAR_RESET = 31'd6554;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    word_t w;
  } point_t;

  typedef struct packed {
    logic valid;
    logic vis;
    logic clip;
    point_t s;
    point_t e;
    logic [REM_W-1:0] rem;
    logic [DIST_W-1:0] den;
    logic [T_W-1:0] t;
  } beat_t;

endpackage

FILE: src/lnpc_div_cell.sv
module lnpc_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  lnpc_pkg::beat_t din,
  output lnpc_pkg::beat_t dout
);
  import lnpc_pkg::*;

  beat_t nxt;
  logic [REM_W-1:0] sh;
  logic [REM_W-1:0] diff;

  // one restoring step, one quotient bit per cell
  always_comb begin
    nxt = din;
    sh = din.rem;
    diff = sh - {1'b0, din.den};
    if (!diff[REM_W-1]) begin
      nxt.rem = {diff[REM_W-2:0], 1'b0};
      nxt.t = {din.t[T_W-2:0], 1'b1};
    end else begin
      nxt.rem = {sh[REM_W-2:0], 1'b0};
      nxt.t = {din.t[T_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.vis <= nxt.vis;
    dout.clip <= nxt.clip;
    dout.s <= nxt.s;
    dout.e <= nxt.e;
    dout.rem <= nxt.rem;
    dout.den <= nxt.den;
    dout.t <= nxt.t;
  end
endmodule

FILE: src/lnpc_blend.sv
module lnpc_blend (
  input  logic                     clk,
  input  logic                     rst,
  input  lnpc_pkg::beat_t          din,
  output logic                     out_valid,
  output logic                     out_vis,
  output lnpc_pkg::point_t         out_s,
  output lnpc_pkg::point_t         out_e
);
  import lnpc_pkg::*;

  localparam int DW = WORD_W + 1;
  localparam int PW = DW + T_W + 1;

  logic signed [DW-1:0] d [4];
  logic signed [PW-1:0] p [4];
  logic signed [PW-1:0] pr [4];
  word_t sr [4];
  word_t sv [4];
  word_t ev [4];
  logic v1, vis1, clip1;
  point_t s1, e1;

  always_comb begin
    sv[0] = din.s.x; sv[1] = din.s.y; sv[2] = din.s.z; sv[3] = din.s.w;
    ev[0] = din.e.x; ev[1] = din.e.y; ev[2] = din.e.z; ev[3] = din.e.w;
    for (int i = 0; i < 4; i++) begin
      d[i] = {ev[i][WORD_W-1], ev[i]} - {sv[i][WORD_W-1], sv[i]};
      p[i] = PW'(d[i]) * $signed({1'b0, din.t});
    end
  end

  // stage 1: products, stage 2: shift and add
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= din.valid;
      out_valid <= v1;
    end
    vis1 <= din.vis;
    clip1 <= din.clip;
    s1 <= din.s;
    e1 <= din.e;
    for (int i = 0; i < 4; i++) pr[i] <= p[i];
    out_vis <= vis1;
    out_e <= e1;
    if (clip1) begin
      out_s.x <= sr[0]; out_s.y <= sr[1]; out_s.z <= sr[2]; out_s.w <= sr[3];
    end else begin
      out_s <= s1;
    end
  end

  always_comb begin
    sr[0] = s1.x + WORD_W'(pr[0] >>> FRAC_BITS);
    sr[1] = s1.y + WORD_W'(pr[1] >>> FRAC_BITS);
    sr[2] = s1.z + WORD_W'(pr[2] >>> FRAC_BITS);
    sr[3] = s1.w + WORD_W'(pr[3] >>> FRAC_BITS);
  end
endmodule

FILE: src/line_near_plane_clip.sv
// Near-plane clipper for line segments. One segment is taken each cycle
// (busy stays low) and its result appears on done after passing through the
// input register, the divider chain and the blend stages; the divider chain
// produces one bit of the clip fraction per cell. The receiver
// cannot stall: results must be taken in the cycle that done is high.
`include "line_near_plane_clip_defines.svh"

module line_near_plane_clip (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 near_z_we,
  input  logic [30:0]          near_z_wdata,
  input  lnpc_pkg::word_t      start_x,
  input  lnpc_pkg::word_t      start_y,
  input  lnpc_pkg::word_t      start_z,
  input  lnpc_pkg::word_t      start_w,
  input  lnpc_pkg::word_t      end_x,
  input  lnpc_pkg::word_t      end_y,
  input  lnpc_pkg::word_t      end_z,
  input  lnpc_pkg::word_t      end_w,
  output logic                 done,
  output logic                 visible,
  output lnpc_pkg::word_t      clipped_start_x,
  output lnpc_pkg::word_t      clipped_start_y,
  output lnpc_pkg::word_t      clipped_start_z,
  output lnpc_pkg::word_t      clipped_start_w,
  output lnpc_pkg::word_t      clipped_end_x,
  output lnpc_pkg::word_t      clipped_end_y,
  output lnpc_pkg::word_t      clipped_end_z,
  output lnpc_pkg::word_t      clipped_end_w
);
  import lnpc_pkg::*;

  logic [WORD_W-2:0] near_z;
  logic signed [DIST_W-1:0] da, db;
  point_t pa, pb;
  beat_t head;
  beat_t chain [NUM_CELLS+1];
  logic swap;
  point_t bs, be;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_z <= NEAR_RESET;
    end else if (near_z_we) begin
      near_z <= near_z_wdata;
    end
  end

  assign busy = 1'b0;

  always_comb begin
    pa = '{start_x, start_y, start_z, start_w};
    pb = '{end_x, end_y, end_z, end_w};
    da = DIST_W'(start_z) - $signed({3'b0, near_z});
    db = DIST_W'(end_z) - $signed({3'b0, near_z});
    swap = da > db;
    bs = swap ? pb : pa;
    be = swap ? pa : pb;
    head.valid = start && !busy;
    head.vis = !(da[DIST_W-1] && db[DIST_W-1]);
    head.clip = head.vis && (da[DIST_W-1] || db[DIST_W-1]);
    head.s = head.clip ? bs : pa;
    head.e = head.clip ? be : pb;
    // numerator near - zs, denominator ze - zs, both positive when clipping
    head.rem = REM_W'($signed({3'b0, near_z}) - DIST_W'(bs.z));
    head.den = DIST_W'(be.z) - DIST_W'(bs.z);
    head.t = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else begin
      chain[0].valid <= head.valid;
    end
    chain[0].vis <= head.vis;
    chain[0].clip <= head.clip;
    chain[0].s <= head.s;
    chain[0].e <= head.e;
    chain[0].rem <= head.rem;
    chain[0].den <= head.den;
    chain[0].t <= head.t;
  end

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    lnpc_div_cell u_cell (.clk(clk), .rst(rst), .din(chain[g]), .dout(chain[g+1]));
  end

  point_t os, oe;

  lnpc_blend u_blend (
    .clk(clk), .rst(rst), .din(chain[NUM_CELLS]),
    .out_valid(done), .out_vis(visible), .out_s(os), .out_e(oe)
  );

  assign clipped_start_x = os.x;
  assign clipped_start_y = os.y;
  assign clipped_start_z = os.z;
  assign clipped_start_w = os.w;
  assign clipped_end_x = oe.x;
  assign clipped_end_y = oe.y;
  assign clipped_end_z = oe.z;
  assign clipped_end_w = oe.w;

  `LNPC_ASSERT_IMP(a_clip_vis, clk, rst, chain[0].valid && chain[0].clip, chain[0].vis)
  `LNPC_ASSERT_IMP(a_t_range, clk, rst, chain[NUM_CELLS].valid && chain[NUM_CELLS].clip,
    chain[NUM_CELLS].t <= T_W'(1 << FRAC_BITS))
  `LNPC_ASSERT_NEXT(a_cell_pass, clk, rst, chain[0].valid, chain[1].valid)
endmodule

FILE: tb/line_near_plane_clip_checker.sv
`timescale 1ns / 100ps

module line_near_plane_clip_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            busy,
  input  logic            near_z_we,
  input  logic [30:0]     near_z_wdata,
  input  lnpc_pkg::word_t start_x,
  input  lnpc_pkg::word_t start_y,
  input  lnpc_pkg::word_t start_z,
  input  lnpc_pkg::word_t start_w,
  input  lnpc_pkg::word_t end_x,
  input  lnpc_pkg::word_t end_y,
  input  lnpc_pkg::word_t end_z,
  input  lnpc_pkg::word_t end_w,
  input  logic            done,
  input  logic            visible,
  input  lnpc_pkg::word_t clipped_start_x,
  input  lnpc_pkg::word_t clipped_start_y,
  input  lnpc_pkg::word_t clipped_start_z,
  input  lnpc_pkg::word_t clipped_start_w,
  input  lnpc_pkg::word_t clipped_end_x,
  input  lnpc_pkg::word_t clipped_end_y,
  input  lnpc_pkg::word_t clipped_end_z,
  input  lnpc_pkg::word_t clipped_end_w,
  output int              fail_count,
  output int              pending
);
  import lnpc_pkg::*;

  typedef struct packed {
    logic   vis;
    point_t s;
    point_t e;
  } clip_out_t;

  clip_out_t   clip_queue[$];
  logic [30:0] near_plane;

  function automatic longint floor_frac(longint v);
    if (v >= 0) return v >>> FRAC_BITS;
    return -((-v + (64'd1 << FRAC_BITS) - 1) >>> FRAC_BITS);
  endfunction

  function automatic word_t lerp_word(longint s, longint e, longint t);
    longint r;
    r = s + floor_frac((e - s) * t);
    return word_t'(r[31:0]);
  endfunction

  function automatic clip_out_t clip_segment(point_t ps, point_t pe, logic [30:0] nz);
    clip_out_t r;
    point_t    a;
    point_t    b;
    longint    nr;
    longint    da;
    longint    db;
    longint    t;
    longint    num;
    longint    den;
    a = ps;
    b = pe;
    nr = longint'(nz);
    da = longint'(a.z) - nr;
    db = longint'(b.z) - nr;
    r.vis = 1'b1;
    if (da < 0 && db < 0) begin
      r.vis = 1'b0;
    end else if (da < 0 || db < 0) begin
      if (da > db) begin
        a = pe;
        b = ps;
      end
      num = nr - longint'(a.z);
      den = longint'(b.z) - longint'(a.z);
      t = (num << FRAC_BITS) / den;
      a.x = lerp_word(a.x, b.x, t);
      a.y = lerp_word(a.y, b.y, t);
      a.z = lerp_word(a.z, b.z, t);
      a.w = lerp_word(a.w, b.w, t);
    end
    r.s = a;
    r.e = b;
    return r;
  endfunction

  assign pending = clip_queue.size();

  always @(posedge clk) begin
    clip_out_t want;
    clip_out_t got;
    if (rst) begin
      near_plane <= NEAR_RESET;
      fail_count <= 0;
      clip_queue.delete();
    end else begin
      if (done) begin
        got.vis = visible;
        got.s = '{clipped_start_x, clipped_start_y, clipped_start_z, clipped_start_w};
        got.e = '{clipped_end_x, clipped_end_y, clipped_end_z, clipped_end_w};
        if (clip_queue.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = clip_queue.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy)
        clip_queue.push_back(clip_segment('{start_x, start_y, start_z, start_w},
                                          '{end_x, end_y, end_z, end_w}, near_plane));
      if (near_z_we) near_plane <= near_z_wdata;
    end
  end
endmodule

FILE: tb/line_near_plane_clip_test.sv
`timescale 1ns / 100ps

module line_near_plane_clip_test;
  import lnpc_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic        near_z_we = 0;
  logic [30:0] near_z_wdata = '0;
  word_t       start_x = 0, start_y = 0, start_z = 0, start_w = 0;
  word_t       end_x = 0, end_y = 0, end_z = 0, end_w = 0;
  logic        done, visible;
  word_t       clipped_start_x, clipped_start_y, clipped_start_z, clipped_start_w;
  word_t       clipped_end_x, clipped_end_y, clipped_end_z, clipped_end_w;
  int          fail_count, pending;
  int          cycle_count = 0;
  logic        no_idle = 0;
  logic [30:0] near_now = NEAR_RESET;

  always #5 clk = ~clk;

  line_near_plane_clip dut (.*);
  line_near_plane_clip_checker checker_u (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("line_near_plane_clip_test: errors");
      $finish;
    end
  end

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return word_t'($urandom_range(0, 16)) - 8;
      3: return word_t'($urandom_range(0, 32'h20000)) - 32'h10000;
      default: return word_t'($urandom());
    endcase
  endfunction

  function automatic word_t near_word(logic [30:0] nz);
    int unsigned d;
    d = (1 << $urandom_range(0, 24));
    case ($urandom_range(0, 3))
      0: return word_t'({1'b0, nz});
      1: return word_t'({1'b0, nz}) - word_t'($urandom_range(0, d));
      2: return word_t'({1'b0, nz}) + word_t'($urandom_range(0, d));
      default: return rand_word();
    endcase
  endfunction

  task automatic send_beat(word_t sx, word_t sy, word_t sz, word_t sw,
                           word_t ex, word_t ey, word_t ez, word_t ew);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1;
    start_x <= sx; start_y <= sy; start_z <= sz; start_w <= sw;
    end_x <= ex; end_y <= ey; end_z <= ez; end_w <= ew;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_near(logic [30:0] v);
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (25) @(posedge clk);
    near_z_we <= 1;
    near_z_wdata <= v;
    near_now = v;
    @(posedge clk);
    near_z_we <= 0;
  endtask

  task automatic random_beats(int n);
    repeat (n)
      send_beat(rand_word(), rand_word(), near_word(near_now), rand_word(),
                rand_word(), rand_word(), near_word(near_now), rand_word());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_beat(0, 0, 0, 0, 0, 0, 0, 0);
    send_beat(1, 2, 6554, 3, 4, 5, 6554, 6);
    send_beat(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_beat(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1,
              32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, -1);
    send_beat(5, 5, -100, 5, 7, 7, -200, 7);
    send_beat(0, 0, 6553, 0, 32'h10000, 32'h10000, 6554, 32'h10000);
    send_beat(-1, -1, 32'h20000, -1, 1, 1, -32'h20000, 1);
    send_beat(32'h7fff_ffff, 32'h7fff_ffff, 6553, 32'h7fff_ffff,
              32'h8000_0000, 32'h8000_0000, 6555, 32'h8000_0000);
    send_beat(-1, -1, -1, -1, -1, -1, -1, -1);
    random_beats(300);
    set_near(31'h7fff_ffff);
    send_beat(0, 0, 32'h7fff_ffff, 0, 9, 9, 32'h8000_0000, 9);
    send_beat(1, 1, 32'h7fff_fffe, 1, 2, 2, 32'h7fff_fffe, 2);
    random_beats(200);
    set_near(31'd0);
    send_beat(3, 3, 0, 3, 4, 4, -1, 4);
    send_beat(3, 3, -1, 3, 4, 4, -1, 4);
    random_beats(200);
    set_near(31'($urandom()));
    random_beats(150);
    no_idle = 1;
    set_near(31'd6554);
    random_beats(150);
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0)
      $display("line_near_plane_clip_test: clean");
    else
      $display("line_near_plane_clip_test: errors");
    $finish;
  end
endmodule
